// File: hw/rtl/nss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types and constants for the brute-force substring search block.
// ----------------------------------------------------------------------------
package nss_pkg;

  localparam int POS_W    = 7;   // start position and match position
  localparam int BYTE_W   = 8;
  localparam int OUT_DW   = 16;  // result word, padded to whole bytes
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // register index of start_position
  localparam logic [CFG_AW-3:0] REG_START_POS = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_START,
    RES_POS
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     accept;    // store the incoming word
    logic     init_pos;  // load start position, clear byte index
    logic     inc_pos;   // next candidate position, clear byte index
    logic     inc_k;     // next pattern byte
    logic     rd;        // read both stores
    logic     res_load;
    res_sel_t res_sel;
    logic     publish;   // move result to output register, clear text
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_zero;
    logic pat_empty;
    logic fits;
    logic bytes_eq;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage : nss_pkg
`default_nettype wire

// File: hw/rtl/naive_substring_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// naive_substring_search
// Loads a pattern and a text one byte per word and, on the last text byte,
// searches the text for the pattern from a configured 1-based position.
//
//   channel  dir  signals                       contents
//   in_      in   tvalid tready tdata tuser tlast  byte, kind (0 pattern,
//                                                   1 text), last of string
//   out_     out  tvalid tready tdata           position, found, overflow
//   cfg_     in   APB psel penable pwrite ...   start_position at 0x0
//
// Pattern and text words are taken one per cycle while idle. A last text word
// starts the search: S_CHECK per candidate position, S_READ and S_CMP per byte
// pair (one read port per store), then S_DONE hands over the result, waiting
// while the output register still holds the previous word; input is held off
// meanwhile. Words are still taken while a result waits at the output. Reset
// clears lengths and flags; the stores are not cleared.
// ----------------------------------------------------------------------------
module naive_substring_search #(
  parameter int MAX_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in: tdata[7:0] byte_value; tuser[0] operation; tlast last_of_string
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  // out: tdata[6:0] match_position, [7] found, [8] overflow, [15:9] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [nss_pkg::OUT_DW-1:0]    out_tdata,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [nss_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [nss_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [nss_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import nss_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             busy;
  logic [POS_W-1:0] start_pos_r, start_pos_nxt;
  logic [POS_W-1:0] out_pos;
  logic             out_found, out_ovf;
  logic             sel_start;

  assign cfg_pready = 1'b1;
  assign sel_start  = (cfg_paddr[CFG_AW-1:2] == REG_START_POS);

  always_comb begin
    start_pos_nxt = start_pos_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_start) begin
      start_pos_nxt = cfg_pwdata[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r <= POS_W'(1);
    end else begin
      start_pos_r <= start_pos_nxt;
    end
  end

  assign cfg_prdata = sel_start ? CFG_DW'(start_pos_r) : '0;

  nss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_last   (in_tlast),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd),
    .busy      (busy)
  );

  nss_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .start_pos  (start_pos_r),
    .out_tready (out_tready),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_pos    (out_pos),
    .out_found  (out_found),
    .out_ovf    (out_ovf)
  );

  assign out_tdata = {(OUT_DW - POS_W - 2)'(0), out_ovf, out_found, out_pos};

`ifndef SYNTHESIS
  // a last text word must start a search and hold off input
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_TEXT) && in_tlast |=> busy && !in_tready)
    else $error("search did not start after last text word");

  // a result that is not found always reports position zero
  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[POS_W] |-> out_tdata[POS_W-1:0] == '0)
    else $error("not found but position nonzero");

  // a new result only appears as the search finishes
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(busy))
    else $error("result without a search");
`endif

endmodule : naive_substring_search
`default_nettype wire

// File: hw/rtl/nss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nss_ctrl
// Sequencer: loads words while idle, then walks the candidate positions
// and compares one byte pair per read/compare step.
// ----------------------------------------------------------------------------
module nss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_op,
  input  logic          in_last,
  input  nss_pkg::sts_t sts,
  output logic          in_tready,
  output nss_pkg::cmd_t cmd,
  output logic          busy
);
  import nss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_TEXT && in_last) begin
            cmd.init_pos = 1'b1;
            state_nxt    = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        priority if (sts.start_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_nxt    = S_DONE;
        end else if (sts.pat_empty) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_START;
          state_nxt    = S_DONE;
        end else if (!sts.fits) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        priority if (sts.bytes_eq && sts.k_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_POS;
          state_nxt    = S_DONE;
        end else if (sts.bytes_eq) begin
          cmd.inc_k = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.inc_pos = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule : nss_ctrl
`default_nettype wire

// File: hw/rtl/nss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nss_datapath
// Pattern and text stores, lengths, overflow flags, position and byte
// counters, comparator and output register.
// ----------------------------------------------------------------------------
module nss_datapath #(
  parameter int MAX_LEN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nss_pkg::cmd_t               cmd,
  input  logic                        in_op,
  input  logic [nss_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_last,
  input  logic [nss_pkg::POS_W-1:0]   start_pos,
  input  logic                        out_tready,
  output nss_pkg::sts_t               sts,
  output logic                        out_valid,
  output logic [nss_pkg::POS_W-1:0]   out_pos,
  output logic                        out_found,
  output logic                        out_ovf
);
  import nss_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PW = ((LW > POS_W) ? LW : POS_W) + 1;

  logic [BYTE_W-1:0] pat_mem [MAX_LEN];
  logic [BYTE_W-1:0] txt_mem [MAX_LEN];

  logic [LW-1:0]     pat_len_r, pat_len_nxt, txt_len_r, txt_len_nxt, pat_len_eff;
  logic              pat_ovf_r, pat_ovf_nxt, txt_ovf_r, txt_ovf_nxt;
  logic              pat_closed_r, pat_closed_nxt;
  logic [PW-1:0]     pos_r, pos_nxt, res_r, res_nxt, txt_addr;
  logic [LW-1:0]     k_r, k_nxt;
  logic [BYTE_W-1:0] pat_q_r, txt_q_r;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_found_r, out_ovf_r;
  logic              pat_wr, txt_wr;

  // a pattern word after a closed pattern starts a fresh one
  assign pat_len_eff = pat_closed_r ? '0 : pat_len_r;
  assign pat_wr = cmd.accept && (in_op == OP_PATTERN) && (pat_len_eff < LW'(MAX_LEN));
  assign txt_wr = cmd.accept && (in_op == OP_TEXT) && (txt_len_r < LW'(MAX_LEN));
  assign txt_addr = pos_r - PW'(1) + PW'(k_r);

  always_comb begin
    pat_len_nxt    = pat_len_r;
    pat_ovf_nxt    = pat_ovf_r;
    pat_closed_nxt = pat_closed_r;
    txt_len_nxt    = txt_len_r;
    txt_ovf_nxt    = txt_ovf_r;
    if (cmd.accept && in_op == OP_PATTERN) begin
      pat_closed_nxt = in_last;
      pat_len_nxt    = pat_len_eff;
      if (pat_closed_r) begin
        pat_ovf_nxt = 1'b0;
      end
      if (pat_wr) begin
        pat_len_nxt = pat_len_eff + LW'(1);
      end else begin
        pat_ovf_nxt = 1'b1;
      end
    end
    if (cmd.accept && in_op == OP_TEXT) begin
      if (txt_wr) begin
        txt_len_nxt = txt_len_r + LW'(1);
      end else begin
        txt_ovf_nxt = 1'b1;
      end
    end
    if (cmd.publish) begin
      txt_len_nxt = '0;
      txt_ovf_nxt = 1'b0;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    k_nxt   = k_r;
    res_nxt = res_r;
    if (cmd.init_pos) begin
      pos_nxt = PW'(start_pos);
      k_nxt   = '0;
    end
    if (cmd.inc_pos) begin
      pos_nxt = pos_r + PW'(1);
      k_nxt   = '0;
    end
    if (cmd.inc_k) begin
      k_nxt = k_r + LW'(1);
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_START: res_nxt = PW'(start_pos);
        RES_POS:   res_nxt = pos_r;
        default:   res_nxt = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r    <= '0;
      pat_ovf_r    <= 1'b0;
      pat_closed_r <= 1'b0;
      txt_len_r    <= '0;
      txt_ovf_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pat_len_r    <= pat_len_nxt;
      pat_ovf_r    <= pat_ovf_nxt;
      pat_closed_r <= pat_closed_nxt;
      txt_len_r    <= txt_len_nxt;
      txt_ovf_r    <= txt_ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
    if (cmd.publish) begin
      out_pos_r   <= res_r[POS_W-1:0];
      out_found_r <= (res_r != '0);
      out_ovf_r   <= pat_ovf_r | txt_ovf_r;
    end
  end

  // stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[pat_len_eff[IW-1:0]] <= in_byte;
    end
    if (cmd.rd) begin
      pat_q_r <= pat_mem[k_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (txt_wr) begin
      txt_mem[txt_len_r[IW-1:0]] <= in_byte;
    end
    if (cmd.rd) begin
      txt_q_r <= txt_mem[txt_addr[IW-1:0]];
    end
  end

  always_comb begin
    sts.start_zero = (start_pos == '0);
    sts.pat_empty  = (pat_len_r == '0);
    sts.fits       = (pos_r + PW'(pat_len_r)) <= (PW'(txt_len_r) + PW'(1));
    sts.bytes_eq   = (pat_q_r == txt_q_r);
    sts.k_last     = ((k_r + LW'(1)) == pat_len_r);
    sts.out_free   = !out_valid_r || out_tready;
  end

  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign out_found = out_found_r;
  assign out_ovf   = out_ovf_r;

endmodule : nss_datapath
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for naive_substring_search. Pattern and text words go in
// over the input stream with random bursts and gaps; every search result is
// checked field by field against a local model of the pattern and text stores,
// under a receiver that stalls on its own pattern and once holds off for long.
// ----------------------------------------------------------------------------
module tb_top;
  import nss_pkg::*;

  localparam int STORE_DEPTH    = 64;
  localparam int RANDOM_WORDS   = 920;
  localparam int PHASE_WORDS    = 160;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_PAD      = 8;
  localparam int END_PAD        = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [BYTE_W-1:0] str_t [$];

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             overflow;
  } search_result_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata    = '0;  // [7:0] byte_value
  logic                in_tuser    = 1'b0; // [0] operation
  logic                in_tlast    = 1'b0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;          // [6:0] position, [7] found, [8] overflow
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // search model state
  logic [BYTE_W-1:0]   pat_mem [STORE_DEPTH];
  logic [BYTE_W-1:0]   txt_mem [STORE_DEPTH];
  int                  pat_len    = 0;
  int                  txt_len    = 0;
  logic                pat_ovf    = 1'b0;
  logic                txt_ovf    = 1'b0;
  logic                pat_closed = 1'b0;
  logic [POS_W-1:0]    start_pos  = 7'd1;

  search_result_t      expected_results [$];

  int   failures       = 0;
  int   words_sent     = 0;
  int   results_seen   = 0;
  int   starts_written = 0;
  int   burst_left     = 0;
  bit   gaps_on        = 1'b0;
  int   rx_mode        = 0;
  bit   hold_request   = 1'b0;
  int   hold_left      = 0;
  int   rx_tick        = 0;
  int   idle_cycles    = 0;

  naive_substring_search #(.MAX_LEN(STORE_DEPTH)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // model
  // ------------------------------------------------------------------
  function automatic int first_match_pos();
    int p;
    int k;
    if (start_pos == '0) return 0;
    if (pat_len == 0) return int'(start_pos);
    for (p = int'(start_pos); p + pat_len <= txt_len + 1; p++) begin
      k = 0;
      while (k < pat_len && txt_mem[p - 1 + k] == pat_mem[k]) k++;
      if (k == pat_len) return p;
    end
    return 0;
  endfunction

  task automatic take_search_word(input logic op, input logic [BYTE_W-1:0] b,
                                  input logic last);
    search_result_t r;
    int             pos;
    if (op == OP_PATTERN) begin
      // a word after a closed pattern opens a fresh one
      if (pat_closed) begin
        pat_len    = 0;
        pat_ovf    = 1'b0;
        pat_closed = 1'b0;
      end
      if (pat_len < STORE_DEPTH) begin
        pat_mem[pat_len] = b;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (last) pat_closed = 1'b1;
    end else begin
      if (txt_len < STORE_DEPTH) begin
        txt_mem[txt_len] = b;
        txt_len++;
      end else begin
        txt_ovf = 1'b1;
      end
      if (last) begin
        pos        = first_match_pos();
        r.position = POS_W'(pos);
        r.found    = (pos != 0);
        r.overflow = pat_ovf | txt_ovf;
        expected_results.push_back(r);
        txt_len = 0;
        txt_ovf = 1'b0;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------
  task automatic send_word(input logic op, input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    take_search_word(op, b, last);
  endtask

  task automatic load_string(input logic op, input str_t s);
    int i;
    for (i = 0; i < s.size(); i++) send_word(op, s[i], i == s.size() - 1);
  endtask

  // drop valid and wait until every search result is back
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic set_start_position(input logic [POS_W-1:0] pos);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_START_POS, 2'b00};
    cfg_pwdata  <= CFG_DW'(pos);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    start_pos = pos;
    starts_written++;
    // read back
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(pos)) begin
      $error("start_position readback: expected %0d, got %0d", pos, cfg_prdata);
      failures++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic str_t to_bytes(input string s);
    str_t q;
    int   i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic str_t repeat_byte(input logic [BYTE_W-1:0] b, input int n);
    str_t q;
    int   i;
    for (i = 0; i < n; i++) q.push_back(b);
    return q;
  endfunction

  // narrow alphabet most of the time, so partial matches are common
  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'h41 + BYTE_W'($urandom_range(0, 1));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [POS_W-1:0] pick_start();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 7'd64;
      2:       return 7'd127;
      3:       return POS_W'($urandom_range(1, 64));
      default: return POS_W'($urandom_range(1, 6));
    endcase
  endfunction

  // ------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick++;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (out_tdata[6:0] !== want.position) begin
          $error("match_position: expected %0d, got %0d", want.position, out_tdata[6:0]);
          failures++;
        end
        if (out_tdata[7] !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tdata[7]);
          failures++;
        end
        if (out_tdata[8] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_tdata[8]);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  // must run before any pattern word has been taken
  task automatic test_empty_pattern();
    load_string(OP_TEXT, to_bytes("hello"));
    set_start_position('0);
    load_string(OP_TEXT, to_bytes("a"));
    set_start_position(7'd127);
    send_word(OP_TEXT, 8'h00, 1'b1);
    set_start_position(7'd1);
    send_word(OP_TEXT, 8'hFF, 1'b1);
  endtask

  task automatic test_directed_search();
    str_t s;
    load_string(OP_PATTERN, to_bytes("ab"));
    load_string(OP_TEXT, to_bytes("xxab"));
    load_string(OP_TEXT, to_bytes("ab"));
    load_string(OP_TEXT, to_bytes("a"));
    set_start_position(7'd3);
    load_string(OP_TEXT, to_bytes("abab"));
    set_start_position(7'd4);
    load_string(OP_TEXT, to_bytes("abab"));
    set_start_position('0);
    load_string(OP_TEXT, to_bytes("ab"));
    // match in the very last text position
    set_start_position(7'd64);
    load_string(OP_PATTERN, to_bytes("z"));
    s = repeat_byte(8'h78, 63);
    s.push_back(8'h7A);
    load_string(OP_TEXT, s);
    set_start_position(7'd1);
    load_string(OP_PATTERN, '{8'h00, 8'hFF});
    load_string(OP_TEXT, '{8'hFF, 8'h00, 8'hFF});
    // pattern left open: later pattern words extend it
    send_word(OP_PATTERN, 8'h71, 1'b0);
    load_string(OP_TEXT, to_bytes("q"));
    send_word(OP_PATTERN, 8'h72, 1'b1);
    load_string(OP_TEXT, to_bytes("qr"));
  endtask

  task automatic test_overflow();
    str_t s;
    load_string(OP_PATTERN, repeat_byte(8'h50, STORE_DEPTH + 1));
    load_string(OP_TEXT, to_bytes("PPP"));
    load_string(OP_TEXT, repeat_byte(8'h50, STORE_DEPTH));
    load_string(OP_PATTERN, to_bytes("K"));
    // final text word is dropped but still starts the search
    s = repeat_byte(8'h78, STORE_DEPTH);
    s.push_back(8'h4B);
    load_string(OP_TEXT, s);
    load_string(OP_TEXT, to_bytes("K"));
  endtask

  task automatic test_output_backpressure();
    settle();
    rx_mode = 0;
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (30) send_word(OP_TEXT, pick_byte(), 1'b1);
    settle();
  endtask

  task automatic test_random_searches();
    str_t pat;
    str_t txt;
    int   base;
    int   next_phase;
    int   len;
    int   off;
    int   i;
    int   kind;
    base       = words_sent;
    next_phase = 0;
    while (words_sent - base < RANDOM_WORDS) begin
      if (words_sent - base >= next_phase) begin
        set_start_position(pick_start());
        rx_mode    = $urandom_range(0, 2);
        gaps_on    = ($urandom_range(0, 3) != 0);
        next_phase = next_phase + PHASE_WORDS;
      end
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        repeat ($urandom_range(1, 3)) send_word(OP_PATTERN, pick_byte(), 1'($urandom_range(0, 1)));
      end else if (kind < 3) begin
        pat.delete();
        repeat ($urandom_range(60, 72)) pat.push_back(pick_byte());
        load_string($urandom_range(0, 1) ? OP_TEXT : OP_PATTERN, pat);
      end else begin
        if ($urandom_range(0, 1)) begin
          pat.delete();
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
          repeat (len) pat.push_back(pick_byte());
          load_string(OP_PATTERN, pat);
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
        txt.delete();
        repeat (len) txt.push_back(pick_byte());
        // plant the current pattern somewhere in the text
        if ($urandom_range(0, 2) != 0 && pat_len > 0 && pat_len <= len) begin
          off = $urandom_range(0, len - pat_len);
          for (i = 0; i < pat_len; i++) txt[off + i] = pat_mem[i];
        end
        load_string(OP_TEXT, txt);
      end
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n   <= 1'b1;
    rx_mode = 0;
    test_empty_pattern();
    rx_mode = 2;
    gaps_on = 1'b1;
    test_directed_search();
    rx_mode = 1;
    test_overflow();
    test_output_backpressure();
    test_random_searches();
    settle();
    repeat (END_PAD) @(posedge clk);
    $display("Checked %0d search results from %0d input words over %0d start position settings.",
             results_seen, words_sent, starts_written);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/nss_pkg.sv
hw/rtl/nss_ctrl.sv
hw/rtl/nss_datapath.sv
hw/rtl/naive_substring_search.sv
tb/tb_top.sv
